FILE: rtl/io_request_router_assert.svh
// Assertion macros for the I/O request router.
// Each macro expands to one concurrent assertion in simulation and to nothing in synthesis.
`ifndef IO_REQUEST_ROUTER_ASSERT_SVH
`define IO_REQUEST_ROUTER_ASSERT_SVH
`ifndef SYNTHESIS
`define IORR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define IORR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define IORR_ASSERT(lbl, clk, rst_n, prop, msg)
`define IORR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/iorr_pkg.sv
`default_nettype none
package iorr_pkg;

	localparam int RANGE_ENTRIES_DEF = 16;
	localparam int CLIENT_COUNT      = 1024;
	localparam int CLIENT_W          = 10;
	localparam int ADDR_W            = 63;

	localparam logic [CLIENT_W:0] CLIENT_LIMIT = (CLIENT_W + 1)'(CLIENT_COUNT);

	localparam logic [1:0] FUNC_ADD   = 2'd0;
	localparam logic [1:0] FUNC_DEL   = 2'd1;
	localparam logic [1:0] FUNC_ROUTE = 2'd2;

	localparam logic [1:0] TYPE_PIO   = 2'd0;
	localparam logic [1:0] TYPE_OTHER = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_LOCAL    = 3'd1;
	localparam logic [2:0] ST_BADARG   = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOCLIENT = 3'd4;

	localparam logic [ADDR_W-1:0] CFG_ADDR_PORT = ADDR_W'(12'hcf8);
	localparam logic [ADDR_W-1:0] CFG_DATA_PORT = ADDR_W'(12'hcfc);
	localparam logic [3:0]        CFG_ACCESS_SIZE = 4'd4;
	localparam logic [31:0]       LOWREG_MASK  = 32'h0000_00fc;
	localparam logic [31:0]       HIGHREG_MASK = 32'h0000_0f00;
	localparam logic [31:0]       CFG_ENABLE   = 32'h8000_0000;
	localparam logic [31:0]       ALL_ONES     = 32'hffff_ffff;

	typedef struct packed {
		logic [1:0]          func;
		logic [CLIENT_W-1:0] owner_id;
		logic [1:0]          req_type;
		logic [ADDR_W-1:0]   address;
		logic [3:0]          access_size;
		logic                is_write;
		logic [31:0]         write_value;
		logic [ADDR_W-1:0]   range_start;
		logic [ADDR_W-1:0]   range_end;
	} in_item_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [CLIENT_W-1:0] dest_client;
		logic [31:0]         read_value;
		logic                is_pci_config;
		logic [7:0]          pci_bus;
		logic [4:0]          pci_device;
		logic [2:0]          pci_function;
		logic [11:0]         pci_register;
	} out_item_t;

	typedef struct packed {
		logic [CLIENT_W-1:0] client;
		logic [1:0]          rtype;
		logic [ADDR_W-1:0]   start_addr;
		logic [ADDR_W-1:0]   end_addr;
	} entry_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic cnt_inc;
		logic cnt_dec;
	} tbl_ctrl_t;

	typedef struct packed {
		logic exact;
		logic contain;
	} match_t;

endpackage
`default_nettype wire

FILE: rtl/io_request_router.sv
// I/O request router.
// Input channel in_valid/in_ready/in_item carries one request item: add a range,
// delete a range, or route an access. Every item yields exactly one result item
// on out_valid/out_ready/out_item. cfg_valid/cfg_data writes the fallback client;
// cfg_ready is always high and writes are expected only while the block is idle.
// Timing: an item is taken only in the idle state. After the decode state, a
// route or delete walks the range table one entry per cycle through a single
// registered RAM read port and one shared compare unit, then passes the resolve
// state and the done state, which loads the output register. A delete that hits
// also shifts the younger entries down, one RAM write per cycle.
// Reset clears the fill count, the latched config address and the fallback
// client; the table RAM itself is not cleared. If the receiver stalls, the result
// holds in the output register; one further item can be taken and worked on, and
// its result waits until the register frees.
`default_nettype none
module io_request_router
	import iorr_pkg::*;
#(
	parameter int RANGE_ENTRIES = RANGE_ENTRIES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire in_item_t            in_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output out_item_t                out_item,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CLIENT_W-1:0] cfg_data
);

	localparam int IDX_W = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(RANGE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(RANGE_ENTRIES);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DECODE  = 3'd1;
	localparam logic [2:0] S_SCAN    = 3'd2;
	localparam logic [2:0] S_RESOLVE = 3'd3;
	localparam logic [2:0] S_SHIFT   = 3'd4;
	localparam logic [2:0] S_DONE    = 3'd5;

	logic [2:0]          state_q;
	logic [CNT_W-1:0]    rd_idx_q, cmp_idx_q, hit_q, sh_idx_q;
	logic                found_q;
	logic [CLIENT_W-1:0] best_q;
	logic [CLIENT_W-1:0] fallback_q;
	logic [31:0]         conf_q;
	in_item_t            req_q;
	logic [ADDR_W:0]     last_q;
	out_item_t           res_q, out_q;
	logic                out_valid_q;

	tbl_ctrl_t           tctl;
	logic [IDX_W-1:0]    tbl_wr_idx, tbl_rd_idx;
	entry_t              tbl_wr_entry, tbl_rd_entry;
	logic [CNT_W-1:0]    tbl_fill;
	match_t              m;

	logic [CLIENT_W-1:0] fb;
	logic                is_route, is_del, is_add;
	logic                bad_arg, cfg_addr_hit, cfg_data_hit;
	logic                need_scan, skip_scan, add_ok, load_out;
	logic                scan_more, shift_more, hit_has_tail;
	logic [CNT_W-1:0]    hit_next;
	logic [CNT_W:0]      sh_plus2;
	logic [11:0]         pci_reg;

	// fallback ids beyond the client count mean no fallback
	assign fb = ({1'b0, fallback_q} < CLIENT_LIMIT) ? fallback_q : '0;

	assign is_add   = req_q.func == FUNC_ADD;
	assign is_del   = req_q.func == FUNC_DEL;
	assign is_route = req_q.func == FUNC_ROUTE;

	assign bad_arg = (req_q.owner_id == '0) || ({1'b0, req_q.owner_id} >= CLIENT_LIMIT)
		|| (req_q.range_end < req_q.range_start);

	// config address port needs a 4-byte access; the data port is any byte of its dword
	assign cfg_addr_hit = (req_q.req_type == TYPE_PIO) && (req_q.address == CFG_ADDR_PORT)
		&& (req_q.access_size == CFG_ACCESS_SIZE);
	assign cfg_data_hit = (req_q.req_type == TYPE_PIO)
		&& (req_q.address[ADDR_W-1:2] == CFG_DATA_PORT[ADDR_W-1:2]);

	assign add_ok    = is_add && !bad_arg && (tbl_fill < ENTRIES_CNT);
	assign need_scan = (is_del && !bad_arg) || (is_route && !cfg_addr_hit && !cfg_data_hit);
	assign skip_scan = (tbl_fill == '0) || (is_route && (req_q.req_type == TYPE_OTHER));

	assign scan_more    = rd_idx_q < tbl_fill;
	assign hit_next     = hit_q + CNT_W'(1);
	assign hit_has_tail = hit_next < tbl_fill;
	assign sh_plus2     = {1'b0, sh_idx_q} + (CNT_W + 1)'(2);
	assign shift_more   = sh_plus2 < {1'b0, tbl_fill};

	// extended register number: low dword bits, high nibble from the address bits 27:24
	assign pci_reg = 12'(conf_q & LOWREG_MASK) + 12'((conf_q >> 16) & HIGHREG_MASK)
		+ 12'(req_q.address[1:0]);

	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// table port control
	always_comb begin
		tctl         = '0;
		tbl_wr_idx   = '0;
		tbl_rd_idx   = '0;
		tbl_wr_entry = tbl_rd_entry;
		unique case (state_q)
			S_DECODE: begin
				if (add_ok) begin
					tctl.wr_en   = 1'b1;
					tctl.cnt_inc = 1'b1;
					tbl_wr_idx   = tbl_fill[IDX_W-1:0];
					tbl_wr_entry = '{client: req_q.owner_id, rtype: req_q.req_type,
						start_addr: req_q.range_start, end_addr: req_q.range_end};
				end else if (need_scan && !skip_scan) begin
					tctl.rd_en = 1'b1;
				end
			end
			S_SCAN: begin
				if (scan_more) begin
					tctl.rd_en = 1'b1;
					tbl_rd_idx = rd_idx_q[IDX_W-1:0];
				end
			end
			S_RESOLVE: begin
				if (is_del && found_q) begin
					if (hit_has_tail) begin
						tctl.rd_en = 1'b1;
						tbl_rd_idx = hit_next[IDX_W-1:0];
					end else begin
						tctl.cnt_dec = 1'b1;
					end
				end
			end
			S_SHIFT: begin
				// move the younger entry one slot down
				tctl.wr_en = 1'b1;
				tbl_wr_idx = sh_idx_q[IDX_W-1:0];
				if (shift_more) begin
					tctl.rd_en = 1'b1;
					tbl_rd_idx = sh_plus2[IDX_W-1:0];
				end else begin
					tctl.cnt_dec = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_idx_q    <= '0;
			cmp_idx_q   <= '0;
			sh_idx_q    <= '0;
			found_q     <= 1'b0;
			conf_q      <= '0;
			fallback_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				fallback_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						found_q <= 1'b0;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (is_route && cfg_addr_hit && req_q.is_write) begin
						conf_q <= req_q.write_value;
					end
					if (need_scan) begin
						if (skip_scan) begin
							state_q <= S_RESOLVE;
						end else begin
							rd_idx_q  <= CNT_W'(1);
							cmp_idx_q <= '0;
							state_q   <= S_SCAN;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if ((is_del && m.exact) || (is_route && m.contain)) begin
						found_q <= 1'b1;
					end
					if (scan_more) begin
						rd_idx_q  <= rd_idx_q + CNT_W'(1);
						cmp_idx_q <= rd_idx_q;
					end else begin
						state_q <= S_RESOLVE;
					end
				end
				S_RESOLVE: begin
					if (is_del && found_q && hit_has_tail) begin
						sh_idx_q <= hit_q;
						state_q  <= S_SHIFT;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SHIFT: begin
					if (shift_more) begin
						sh_idx_q <= sh_idx_q + CNT_W'(1);
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res_q;
		end
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					req_q  <= in_item;
					last_q <= {1'b0, in_item.address} + (ADDR_W + 1)'(in_item.access_size);
					res_q  <= '0;
				end
			end
			S_DECODE: begin
				priority if (!is_route) begin
					if (!(is_add || is_del) || bad_arg) begin
						res_q.status <= ST_BADARG;
					end else if (is_add && !add_ok) begin
						res_q.status <= ST_FULL;
					end
				end else if (cfg_addr_hit) begin
					res_q.status     <= ST_LOCAL;
					res_q.read_value <= req_q.is_write ? '0 : conf_q;
				end else if (cfg_data_hit) begin
					if ((conf_q & CFG_ENABLE) == '0) begin
						res_q.status     <= ST_LOCAL;
						res_q.read_value <= req_q.is_write ? '0 : ALL_ONES;
					end else if (fb == '0) begin
						res_q.status <= ST_NOCLIENT;
					end else begin
						res_q.dest_client   <= fb;
						res_q.is_pci_config <= 1'b1;
						res_q.pci_bus       <= conf_q[23:16];
						res_q.pci_device    <= conf_q[15:11];
						res_q.pci_function  <= conf_q[10:8];
						res_q.pci_register  <= pci_reg;
					end
				end else begin
				end
			end
			S_SCAN: begin
				// keep the newest exact hit; for a route the highest client id wins
				if (is_del && m.exact) begin
					hit_q <= cmp_idx_q;
				end
				if (is_route && m.contain && (!found_q || (tbl_rd_entry.client >= best_q))) begin
					best_q <= tbl_rd_entry.client;
				end
			end
			S_RESOLVE: begin
				if (is_route) begin
					if (found_q) begin
						res_q.dest_client <= best_q;
					end else if (fb != '0) begin
						res_q.dest_client <= fb;
					end else begin
						res_q.status <= ST_NOCLIENT;
					end
				end
			end
			default: begin
			end
		endcase
	end

	iorr_table #(
		.ENTRIES (RANGE_ENTRIES),
		.IDX_W   (IDX_W),
		.CNT_W   (CNT_W)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (tctl),
		.wr_idx   (tbl_wr_idx),
		.wr_entry (tbl_wr_entry),
		.rd_idx   (tbl_rd_idx),
		.rd_entry (tbl_rd_entry),
		.fill     (tbl_fill)
	);

	iorr_match u_match (
		.entry      (tbl_rd_entry),
		.is_route   (is_route),
		.req_client (req_q.owner_id),
		.req_type   (req_q.req_type),
		.addr       (req_q.address),
		.last       (last_q),
		.key_start  (req_q.range_start),
		.key_end    (req_q.range_end),
		.fb         (fb),
		.m          (m)
	);

	assign in_ready  = state_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`include "io_request_router_assert.svh"

	`IORR_ASSERT(a_fill_bound, clk, arst_n, tbl_fill <= ENTRIES_CNT, "fill count beyond table size")
	`IORR_ASSERT_IMPL(a_scan_idx, clk, arst_n, state_q == S_SCAN,
		cmp_idx_q < tbl_fill, "compare index past fill")
	`IORR_ASSERT_IMPL(a_shift_idx, clk, arst_n, state_q == S_SHIFT,
		sh_plus2 <= {1'b0, tbl_fill}, "shift source past fill")
	`IORR_ASSERT_IMPL(a_pci_target, clk, arst_n, out_valid_q && out_q.is_pci_config,
		(out_q.status == ST_OK) && (out_q.dest_client != '0), "config access without target")

endmodule
`default_nettype wire

FILE: rtl/iorr_table.sv
`default_nettype none
module iorr_table
	import iorr_pkg::*;
#(
	parameter int ENTRIES = RANGE_ENTRIES_DEF,
	parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tbl_ctrl_t        ctrl,
	input  wire logic [IDX_W-1:0] wr_idx,
	input  wire entry_t           wr_entry,
	input  wire logic [IDX_W-1:0] rd_idx,
	output entry_t                rd_entry,
	output logic      [CNT_W-1:0] fill
);

	entry_t           mem [ENTRIES];
	entry_t           rd_q;
	logic [CNT_W-1:0] fill_q;

	// entries stay packed from slot 0, so a count stands in for per-entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctrl.cnt_inc) begin
			fill_q <= fill_q + CNT_W'(1);
		end else if (ctrl.cnt_dec) begin
			fill_q <= fill_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_idx] <= wr_entry;
		end
		if (ctrl.rd_en) begin
			rd_q <= mem[rd_idx];
		end
	end

	assign rd_entry = rd_q;
	assign fill     = fill_q;

endmodule
`default_nettype wire

FILE: rtl/iorr_match.sv
`default_nettype none
module iorr_match
	import iorr_pkg::*;
(
	input  wire entry_t              entry,
	input  wire logic                is_route,
	input  wire logic [CLIENT_W-1:0] req_client,
	input  wire logic [1:0]          req_type,
	input  wire logic [ADDR_W-1:0]   addr,
	input  wire logic [ADDR_W:0]     last,
	input  wire logic [ADDR_W-1:0]   key_start,
	input  wire logic [ADDR_W-1:0]   key_end,
	input  wire logic [CLIENT_W-1:0] fb,
	output match_t                   m
);

	logic [ADDR_W-1:0] op_a;
	logic [ADDR_W:0]   op_b;
	logic [ADDR_W:0]   ent_end;
	logic              a_eq, a_ge, b_eq, b_le, type_eq;

	// one set of comparators on shared operands: bounds test for a route, exact test for a delete
	assign op_a    = is_route ? addr : key_start;
	assign op_b    = is_route ? last : {1'b0, key_end};
	assign ent_end = {1'b0, entry.end_addr};

	assign a_eq    = op_a == entry.start_addr;
	assign a_ge    = op_a >= entry.start_addr;
	assign b_eq    = op_b == ent_end;
	assign b_le    = op_b <= ent_end;
	assign type_eq = entry.rtype == req_type;

	assign m.exact   = type_eq && (entry.client == req_client) && a_eq && b_eq;
	assign m.contain = type_eq && (entry.client != fb) && a_ge && b_le;

endmodule
`default_nettype wire
